// File: src/badm_pkg.sv
// Shared constants, codes and types for the bus address decoder.
package badm_pkg;

  localparam int RAM_ADDR_BITS = 16;
  localparam int ROM_ADDR_BITS = 15;
  localparam int RAM_ROW_BITS  = RAM_ADDR_BITS - 2;
  localparam int ROM_ROW_BITS  = ROM_ADDR_BITS - 2;
  localparam int RAM_ROWS      = 1 << RAM_ROW_BITS;
  localparam int ROM_ROWS      = 1 << ROM_ROW_BITS;
  localparam logic [31:0] RAM_DEPTH = 32'(1) << RAM_ADDR_BITS;
  localparam logic [31:0] ROM_DEPTH = 32'(1) << ROM_ADDR_BITS;

  localparam int CFG_IDX_W = 3;

  localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFC;
  localparam logic [31:0] ONES_LONG = 32'hFFFF_FFFF;
  localparam logic [31:0] ONES_WORD = 32'h0000_FFFF;
  localparam logic [31:0] ONES_BYTE = 32'h0000_00FF;

  localparam logic [16:0] RAM_SIZE_RST    = 17'd65536;
  localparam logic [31:0] ROM_BASE_RST    = 32'h0100_0000;
  localparam logic [15:0] ROM_SIZE_RST    = 16'd32768;
  localparam logic [31:0] DEVICE_BASE_RST = 32'hFF00_0000;
  localparam logic [24:0] DEVICE_SIZE_RST = 25'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAM_SIZE    = 3'd0,
    REG_ROM_BASE    = 3'd1,
    REG_ROM_SIZE    = 3'd2,
    REG_DEVICE_BASE = 3'd3,
    REG_DEVICE_SIZE = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_CPU_READ  = 2'd0,
    CMD_CPU_WRITE = 2'd1,
    CMD_PEEK      = 2'd2,
    CMD_POKE      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2,
    SZ_ALT  = 2'd3
  } size_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_BUS_ERROR = 3'd1,
    ST_DEVICE    = 3'd2,
    ST_ROM_WRITE = 3'd3,
    ST_OVERRUN   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_ONES = 2'd1,
    SRC_RAM  = 2'd2,
    SRC_ROM  = 2'd3
  } src_t;

  typedef struct packed {
    status_t    status;
    logic       hit;
    src_t       src;
    logic [1:0] size;
    logic [1:0] lo;
  } stage_t;

endpackage

// File: src/badm_in_if.sv
// Access request channel.
interface badm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  access_size;
  logic [31:0] address;
  logic [31:0] write_data;

  modport source (output valid, cmd, access_size, address, write_data, input ready);
  modport sink   (input valid, cmd, access_size, address, write_data, output ready);
endinterface

// File: src/badm_out_if.sv
// Access result channel.
interface badm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [2:0]  status;
  logic        device_hit;

  modport source (output valid, read_data, status, device_hit, input ready);
  modport sink   (input valid, read_data, status, device_hit, output ready);
endinterface

// File: src/badm_cfg_if.sv
// Configuration write channel.
interface badm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/badm_ram.sv
// Generic single-port RAM with registered read.
module badm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: src/bus_address_decoder_memory.sv
// Top level: bus address decoder with RAM and ROM backing store.
//
// Channels: in_bus takes one access (cmd, access_size, address, write_data),
// out_bus returns one result per access (read_data, status, device_hit), and
// cfg_bus writes the window registers by index; cfg_bus is always ready.
// Each store is split into four byte lanes so an unaligned access of up to
// four bytes touches every lane at most once, with all lanes accessed in the same cycle.
// The lane memories are read or written in the accept cycle; the registered
// read data is packed big-endian into the output register when that
// register is free (empty, or its result taken by out_bus).
// Throughput is one transaction per cycle while out_bus keeps up; it is set
// by the single port of each lane memory.
// When out_bus stalls, the result holds in the output register and one more
// transaction waits in the read stage; in_bus then drops ready.
// Reset sets the registers to their defaults and starts a pass that zeroes
// the RAM one row per cycle, all 2^(RAM_ADDR_BITS-2) = 16384 rows; in_bus
// stays not ready until it ends. ROM contents are undefined until poked.
module bus_address_decoder_memory (
  input  logic              clk,
  input  logic              rst_n,
  badm_in_if.sink           in_bus,
  badm_out_if.source        out_bus,
  badm_cfg_if.sink          cfg_bus
);
  import badm_pkg::*;

  logic [16:0] ram_size_r;
  logic [31:0] rom_base_r;
  logic [15:0] rom_size_r;
  logic [31:0] device_base_r;
  logic [24:0] device_size_r;

  logic [31:0] fault_address_r;
  logic        fault_was_write_r;
  logic        fault_seen_r;

  logic                    clr_active_r;
  logic [RAM_ROW_BITS-1:0] clr_row_r;

  logic   s1_valid_r;
  stage_t s1_r;
  logic   out_valid_r;
  logic [31:0] out_data_r;
  status_t     out_status_r;
  logic        out_hit_r;

  logic        out_free;
  logic        accept;
  logic [31:0] ram_eff;
  logic [31:0] rom_eff;
  logic [31:0] rom_off;
  logic [31:0] off;
  logic [31:0] region_size;
  logic        dev;
  logic        in_ram;
  logic        in_rom;
  logic        fits;
  logic [2:0]  nbytes;
  logic [1:0]  nm1;
  logic        ram_wr;
  logic        rom_wr;
  logic        set_fault;
  stage_t      dec;

  logic [7:0] ram_rd [4];
  logic [7:0] rom_rd [4];
  logic [7:0] wr_byte [4];
  logic       lane_on [4];
  logic [7:0] lane_byte [4];
  logic [7:0] be_byte [4];
  logic [31:0] packed_data;
  logic [31:0] ones_data;
  logic [31:0] result_data;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_size_r    <= RAM_SIZE_RST;
      rom_base_r    <= ROM_BASE_RST;
      rom_size_r    <= ROM_SIZE_RST;
      device_base_r <= DEVICE_BASE_RST;
      device_size_r <= DEVICE_SIZE_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_RAM_SIZE:    ram_size_r    <= cfg_bus.data[16:0];
        REG_ROM_BASE:    rom_base_r    <= cfg_bus.data;
        REG_ROM_SIZE:    rom_size_r    <= cfg_bus.data[15:0];
        REG_DEVICE_BASE: device_base_r <= cfg_bus.data & WORD_MASK;
        REG_DEVICE_SIZE: device_size_r <= cfg_bus.data[24:0];
        default: ;
      endcase
    end
  end

  assign out_free     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !clr_active_r && (!s1_valid_r || out_free);
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    ram_eff = ({15'b0, ram_size_r} > RAM_DEPTH) ? RAM_DEPTH : {15'b0, ram_size_r};
    rom_eff = ({16'b0, rom_size_r} > ROM_DEPTH) ? ROM_DEPTH : {16'b0, rom_size_r};
    rom_off = in_bus.address - rom_base_r;
    dev     = ((in_bus.address & WORD_MASK) - device_base_r) < {7'b0, device_size_r};
    in_ram  = in_bus.address < ram_eff;
    in_rom  = !in_ram && (rom_off < rom_eff);
    off         = in_ram ? in_bus.address : rom_off;
    region_size = in_ram ? ram_eff : rom_eff;
    unique case (in_bus.access_size)
      SZ_BYTE: nbytes = 3'd1;
      SZ_WORD: nbytes = 3'd2;
      default: nbytes = 3'd4;
    endcase
    nm1  = 2'(nbytes - 3'd1);
    fits = (in_ram || in_rom) &&
           (({1'b0, off} + {30'b0, nbytes}) <= {1'b0, region_size});

    dec.status = ST_DONE;
    dec.hit    = 1'b0;
    dec.src    = SRC_ZERO;
    dec.size   = in_bus.access_size;
    dec.lo     = off[1:0];
    ram_wr     = 1'b0;
    rom_wr     = 1'b0;
    set_fault  = 1'b0;

    if (in_bus.cmd != CMD_POKE && dev) begin
      dec.status = ST_DEVICE;
      dec.hit    = 1'b1;
    end else begin
      unique case (in_bus.cmd)
        CMD_CPU_READ: begin
          if (!fits) begin
            set_fault  = 1'b1;
            dec.status = ST_BUS_ERROR;
          end else begin
            dec.src = in_ram ? SRC_RAM : SRC_ROM;
          end
        end
        CMD_CPU_WRITE: begin
          if (!in_ram && !in_rom) begin
            set_fault  = 1'b1;
            dec.status = ST_BUS_ERROR;
          end else if (in_rom) begin
            dec.status = ST_ROM_WRITE;
          end else if (!fits) begin
            dec.status = ST_OVERRUN;
          end else begin
            ram_wr = 1'b1;
          end
        end
        CMD_PEEK: begin
          if (!fits) begin
            dec.src = SRC_ONES;
          end else begin
            dec.src = in_ram ? SRC_RAM : SRC_ROM;
          end
        end
        CMD_POKE: begin
          if ((in_ram || in_rom) && !fits) begin
            dec.status = ST_OVERRUN;
          end else if (fits) begin
            ram_wr = in_ram;
            rom_wr = in_rom;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_address_r   <= '0;
      fault_was_write_r <= 1'b0;
      fault_seen_r      <= 1'b0;
    end else if (accept && set_fault) begin
      fault_address_r   <= in_bus.address;
      fault_was_write_r <= (in_bus.cmd == CMD_CPU_WRITE);
      fault_seen_r      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_row_r    <= '0;
    end else if (clr_active_r) begin
      clr_row_r <= clr_row_r + 1'b1;
      if (clr_row_r == RAM_ROW_BITS'(RAM_ROWS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [1:0]              idx;
    logic [1:0]              shift;
    logic                    carry;
    logic [RAM_ROW_BITS-1:0] ram_row;
    logic [ROM_ROW_BITS-1:0] rom_row;
    logic                    ram_en;
    logic                    ram_we;
    logic                    rom_en;
    logic                    rom_we;
    logic [RAM_ROW_BITS-1:0] ram_addr;
    logic [7:0]              ram_wdata;

    assign idx          = 2'(l) - off[1:0];
    assign shift        = nm1 - idx;
    assign lane_on[l]   = idx <= nm1;
    assign wr_byte[l]   = in_bus.write_data[{shift, 3'b000} +: 8];
    assign carry        = 2'(l) < off[1:0];
    assign ram_row      = off[RAM_ADDR_BITS-1:2] + RAM_ROW_BITS'(carry);
    assign rom_row      = off[ROM_ADDR_BITS-1:2] + ROM_ROW_BITS'(carry);

    assign ram_en    = clr_active_r ||
                       (accept && ((dec.src == SRC_RAM) || (ram_wr && lane_on[l])));
    assign ram_we    = clr_active_r || (accept && ram_wr);
    assign ram_addr  = clr_active_r ? clr_row_r : ram_row;
    assign ram_wdata = clr_active_r ? 8'h00 : wr_byte[l];
    assign rom_en    = accept && ((dec.src == SRC_ROM) || (rom_wr && lane_on[l]));
    assign rom_we    = accept && rom_wr;

    badm_ram #(.WIDTH(8), .DEPTH(RAM_ROWS)) u_ram (
      .clk   (clk),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rd[l])
    );

    badm_ram #(.WIDTH(8), .DEPTH(ROM_ROWS)) u_rom (
      .clk   (clk),
      .en    (rom_en),
      .we    (rom_we),
      .addr  (rom_row),
      .wdata (wr_byte[l]),
      .rdata (rom_rd[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= dec;
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_byte[l] = (s1_r.src == SRC_ROM) ? rom_rd[l] : ram_rd[l];
    end
    for (int i = 0; i < 4; i++) begin
      be_byte[i] = lane_byte[2'(s1_r.lo + 2'(i))];
    end
    unique case (s1_r.size)
      SZ_BYTE: begin
        packed_data = {24'b0, be_byte[0]};
        ones_data   = ONES_BYTE;
      end
      SZ_WORD: begin
        packed_data = {16'b0, be_byte[0], be_byte[1]};
        ones_data   = ONES_WORD;
      end
      default: begin
        packed_data = {be_byte[0], be_byte[1], be_byte[2], be_byte[3]};
        ones_data   = ONES_LONG;
      end
    endcase
    unique case (s1_r.src)
      SRC_ZERO: result_data = '0;
      SRC_ONES: result_data = ones_data;
      default:  result_data = packed_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_data_r   <= result_data;
      out_status_r <= s1_r.status;
      out_hit_r    <= s1_r.hit;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_data  = out_data_r;
  assign out_bus.status     = out_status_r;
  assign out_bus.device_hit = out_hit_r;

endmodule

// File: test/bus_address_decoder_memory_test.sv
// Self-checking testbench for the bus address decoder with RAM and ROM store.
`timescale 1ns / 100ps

module bus_address_decoder_memory_test;
  import badm_pkg::*;

  localparam int RAM_BYTES = 1 << RAM_ADDR_BITS;
  localparam int ROM_BYTES = 1 << ROM_ADDR_BITS;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum {REGION_NONE, REGION_RAM, REGION_ROM} region_t;

  typedef struct packed {
    logic [16:0] ram_size;
    logic [31:0] rom_base;
    logic [15:0] rom_size;
    logic [31:0] dev_base;
    logic [24:0] dev_size;
  } window_cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    size_t       access_size;
    logic [31:0] address;
    logic [31:0] write_data;
  } access_t;

  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
    logic        device_hit;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  badm_in_if  in_if ();
  badm_out_if out_if ();
  badm_cfg_if cfg_if ();

  bus_address_decoder_memory dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always #5 clk = ~clk;

  window_cfg_t live_cfg = '{RAM_SIZE_RST, ROM_BASE_RST, ROM_SIZE_RST, DEVICE_BASE_RST,
                            DEVICE_SIZE_RST};
  window_cfg_t plan_cfg = '{RAM_SIZE_RST, ROM_BASE_RST, ROM_SIZE_RST, DEVICE_BASE_RST,
                            DEVICE_SIZE_RST};
  bit [7:0] ram_img [RAM_BYTES];
  bit [7:0] rom_img [ROM_BYTES];
  bit       rom_filled [ROM_BYTES];

  access_t  access_backlog [$];
  outcome_t results_due [$];

  bit in_fire;
  bit out_fire;
  bit in_busy;
  int gap_left;
  int stall_left;
  int tx_gap_max;
  int rx_stall_max;
  int mismatches;
  int unsigned cycle_count;

  function automatic void apply_reg(inout window_cfg_t c, input logic [2:0] idx,
                                    input logic [31:0] v);
    case (idx)
      REG_RAM_SIZE:    c.ram_size = v[16:0];
      REG_ROM_BASE:    c.rom_base = v;
      REG_ROM_SIZE:    c.rom_size = v[15:0];
      REG_DEVICE_BASE: c.dev_base = v & WORD_MASK;
      REG_DEVICE_SIZE: c.dev_size = v[24:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned byte_count(input logic [1:0] sz);
    case (sz)
      SZ_BYTE: return 1;
      SZ_WORD: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic logic [31:0] ram_limit(input window_cfg_t c);
    return (32'(c.ram_size) > RAM_DEPTH) ? RAM_DEPTH : 32'(c.ram_size);
  endfunction

  function automatic logic [31:0] rom_limit(input window_cfg_t c);
    return (32'(c.rom_size) > ROM_DEPTH) ? ROM_DEPTH : 32'(c.rom_size);
  endfunction

  function automatic bit in_device(input window_cfg_t c, input logic [31:0] addr);
    logic [31:0] rel;
    rel = (addr & WORD_MASK) - c.dev_base;
    return rel < 32'(c.dev_size);
  endfunction

  function automatic void locate(input window_cfg_t c, input logic [31:0] addr,
                                 input int unsigned n, output region_t where,
                                 output logic [31:0] off, output bit fits);
    logic [31:0] lim;
    logic [31:0] rel;
    where = REGION_NONE;
    off = '0;
    lim = '0;
    rel = addr - c.rom_base;
    if (addr < ram_limit(c)) begin
      where = REGION_RAM;
      off = addr;
      lim = ram_limit(c);
    end else if (rel < rom_limit(c)) begin
      where = REGION_ROM;
      off = rel;
      lim = rom_limit(c);
    end
    fits = (where != REGION_NONE) && ({1'b0, off} + 33'(n) <= {1'b0, lim});
  endfunction

  function automatic logic [31:0] fetch_bytes(input region_t where, input logic [31:0] off,
                                              input int unsigned n);
    logic [31:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++) begin
      v = {v[23:0], (where == REGION_RAM) ? ram_img[off + i] : rom_img[off + i]};
    end
    return v;
  endfunction

  function automatic void store_bytes(input region_t where, input logic [31:0] off,
                                      input int unsigned n, input logic [31:0] v);
    logic [7:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      b = v[8 * (n - 1 - i) +: 8];
      if (where == REGION_RAM) ram_img[off + i] = b;
      else rom_img[off + i] = b;
    end
  endfunction

  function automatic outcome_t decode_access(input access_t a);
    outcome_t    r;
    int unsigned n;
    region_t     where;
    logic [31:0] off;
    bit          fits;
    n = byte_count(a.access_size);
    r.read_data = '0;
    r.status = ST_DONE;
    r.device_hit = 1'b0;
    locate(live_cfg, a.address, n, where, off, fits);
    if (a.cmd != CMD_POKE && in_device(live_cfg, a.address)) begin
      r.status = ST_DEVICE;
      r.device_hit = 1'b1;
    end else begin
      case (a.cmd)
        CMD_CPU_READ: begin
          if (!fits) r.status = ST_BUS_ERROR;
          else r.read_data = fetch_bytes(where, off, n);
        end
        CMD_CPU_WRITE: begin
          if (where == REGION_NONE) r.status = ST_BUS_ERROR;
          else if (where == REGION_ROM) r.status = ST_ROM_WRITE;
          else if (!fits) r.status = ST_OVERRUN;
          else store_bytes(where, off, n, a.write_data);
        end
        CMD_PEEK: begin
          if (!fits) r.read_data = (n == 1) ? ONES_BYTE : (n == 2) ? ONES_WORD : ONES_LONG;
          else r.read_data = fetch_bytes(where, off, n);
        end
        default: begin
          if (where != REGION_NONE) begin
            if (!fits) r.status = ST_OVERRUN;
            else store_bytes(where, off, n, a.write_data);
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("tb: %0t %s mismatch: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    access_t  seen;
    out_fire = out_if.valid && out_if.ready;
    in_fire = in_if.valid && in_if.ready;
    if (out_fire) begin
      if (results_due.size() == 0) begin
        note_mismatch("unexpected transaction", out_if.read_data, '0);
      end else begin
        want = results_due.pop_front();
        if (out_if.read_data !== want.read_data)
          note_mismatch("read_data", out_if.read_data, want.read_data);
        if (out_if.status !== want.status)
          note_mismatch("status", 32'(out_if.status), 32'(want.status));
        if (out_if.device_hit !== want.device_hit)
          note_mismatch("device_hit", 32'(out_if.device_hit), 32'(want.device_hit));
      end
    end
    if (cfg_if.valid && cfg_if.ready) apply_reg(live_cfg, cfg_if.index, cfg_if.data);
    if (in_fire) begin
      seen.cmd = cmd_t'(in_if.cmd);
      seen.access_size = size_t'(in_if.access_size);
      seen.address = in_if.address;
      seen.write_data = in_if.write_data;
      results_due.push_back(decode_access(seen));
    end
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin : drive
    access_t a;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_busy = 1'b0;
      gap_left = 0;
    end else begin
      if (in_fire) begin
        in_busy = 1'b0;
        gap_left = $urandom_range(0, tx_gap_max);
      end
      if (!in_busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (access_backlog.size() > 0) begin
          a = access_backlog.pop_front();
          in_if.cmd <= a.cmd;
          in_if.access_size <= a.access_size;
          in_if.address <= a.address;
          in_if.write_data <= a.write_data;
          in_if.valid <= 1'b1;
          in_busy = 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_fire) stall_left = $urandom_range(0, rx_stall_max);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] v);
    apply_reg(plan_cfg, idx, v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic program_windows(input logic [31:0] ram_sz, input logic [31:0] rom_b,
                                 input logic [31:0] rom_sz, input logic [31:0] dev_b,
                                 input logic [31:0] dev_sz);
    set_reg(REG_RAM_SIZE, ram_sz);
    set_reg(REG_ROM_BASE, rom_b);
    set_reg(REG_ROM_SIZE, rom_sz);
    set_reg(REG_DEVICE_BASE, dev_b);
    set_reg(REG_DEVICE_SIZE, dev_sz);
    set_reg(REG_SPARE, $urandom());
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Turn reads of never-written ROM into pokes, so every ROM byte read has a value.
  task automatic queue_access(input cmd_t cmd, input size_t sz, input logic [31:0] addr,
                              input logic [31:0] data);
    int unsigned n;
    region_t     where;
    logic [31:0] off;
    bit          fits;
    bit          blank;
    access_t     a;
    n = byte_count(sz);
    locate(plan_cfg, addr, n, where, off, fits);
    if (where == REGION_ROM && fits) begin
      blank = 1'b0;
      for (int unsigned i = 0; i < n; i++) if (!rom_filled[off + i]) blank = 1'b1;
      if (blank && (cmd == CMD_CPU_READ || cmd == CMD_PEEK) && !in_device(plan_cfg, addr))
        cmd = CMD_POKE;
      if (cmd == CMD_POKE)
        for (int unsigned i = 0; i < n; i++) rom_filled[off + i] = 1'b1;
    end
    a.cmd = cmd;
    a.access_size = sz;
    a.address = addr;
    a.write_data = data;
    access_backlog.push_back(a);
  endtask

  function automatic logic [31:0] pick_address();
    logic [31:0] ram_end;
    logic [31:0] rom_end;
    ram_end = ram_limit(plan_cfg);
    rom_end = rom_limit(plan_cfg);
    case ($urandom_range(0, 8))
      0: return $urandom_range(0, 63);
      1: return ram_end - $urandom_range(0, 8);
      2: return $urandom_range(0, ram_end);
      3: return plan_cfg.rom_base + $urandom_range(0, rom_end);
      4: return plan_cfg.rom_base + rom_end - $urandom_range(0, 8);
      5: return plan_cfg.rom_base - $urandom_range(1, 4);
      6: return plan_cfg.dev_base + $urandom_range(0, 32'(plan_cfg.dev_size) + 8) - 4;
      7: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic drain();
    while (access_backlog.size() != 0 || in_busy || results_due.size() != 0)
      @(posedge clk);
  endtask

  // Short runs around one address so writes are read back; the odd item lands anywhere.
  task automatic run_phase(input int count);
    int          issued;
    int          run_len;
    logic [31:0] base;
    logic [31:0] addr;
    tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
    rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
    issued = 0;
    while (issued < count) begin
      base = pick_address();
      run_len = $urandom_range(1, 6);
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 7) == 0) addr = $urandom();
        else addr = base + $urandom_range(0, 6) - 3;
        queue_access(cmd_t'($urandom_range(0, 3)), size_t'($urandom_range(0, 3)), addr,
                     $urandom());
        issued++;
      end
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_CPU_READ;
    in_if.access_size = SZ_BYTE;
    in_if.address = '0;
    in_if.write_data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_RAM_SIZE;
    cfg_if.data = '0;
    tx_gap_max = 0;
    rx_stall_max = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_phase(80);

    program_windows(32'h0001_0000, 32'h0100_0000, 32'h0000_8000, 32'h0000_8000, 32'd16);
    queue_access(CMD_CPU_WRITE, SZ_LONG, 32'h0000_0000, 32'h1122_3344);
    queue_access(CMD_CPU_READ,  SZ_LONG, 32'h0000_0000, 32'h0000_0000);
    queue_access(CMD_CPU_READ,  SZ_BYTE, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_access(CMD_CPU_READ,  SZ_WORD, 32'h0000_0003, 32'h0000_0000);
    queue_access(CMD_PEEK,      SZ_WORD, 32'h0000_0002, 32'h0000_0000);
    queue_access(CMD_CPU_WRITE, SZ_BYTE, 32'h0000_FFFF, 32'hFFFF_FFAB);
    queue_access(CMD_CPU_WRITE, SZ_WORD, 32'h0000_FFFF, 32'hFFFF_FFFF);
    queue_access(CMD_CPU_READ,  SZ_LONG, 32'h0000_FFFE, 32'h0000_0000);
    queue_access(CMD_PEEK,      SZ_LONG, 32'h0000_FFFD, 32'h0000_0000);
    queue_access(CMD_CPU_READ,  SZ_BYTE, 32'h0000_FFFF, 32'h0000_0000);
    queue_access(CMD_POKE,      SZ_LONG, 32'h0100_0000, 32'hDEAD_BEEF);
    queue_access(CMD_CPU_READ,  SZ_LONG, 32'h0100_0000, 32'h0000_0000);
    queue_access(CMD_CPU_WRITE, SZ_LONG, 32'h0100_0000, 32'h5555_AAAA);
    queue_access(CMD_POKE,      SZ_LONG, 32'h0100_7FFE, 32'h1234_5678);
    queue_access(CMD_CPU_WRITE, SZ_WORD, 32'h0100_7FFF, 32'h0000_9999);
    queue_access(CMD_CPU_READ,  SZ_BYTE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_access(CMD_CPU_WRITE, SZ_LONG, 32'h0200_0000, 32'hCAFE_F00D);
    queue_access(CMD_PEEK,      SZ_BYTE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_access(CMD_POKE,      SZ_WORD, 32'h0200_0000, 32'h0000_7777);
    queue_access(CMD_CPU_READ,  SZ_LONG, 32'h0000_8000, 32'h0000_0000);
    queue_access(CMD_CPU_WRITE, SZ_BYTE, 32'h0000_800F, 32'h0000_0042);
    queue_access(CMD_PEEK,      SZ_WORD, 32'h0000_8003, 32'h0000_0000);
    queue_access(CMD_POKE,      SZ_LONG, 32'h0000_8000, 32'h8765_4321);
    queue_access(CMD_CPU_READ,  SZ_LONG, 32'h0000_8010, 32'h0000_0000);
    queue_access(CMD_CPU_READ,  SZ_ALT,  32'h0000_0000, 32'h0000_0000);
    run_phase(100);

    program_windows(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd8);
    run_phase(130);
    program_windows(32'h0000_0000, 32'hFFFF_FFF0, 32'h0000_8000, 32'h8000_0000,
                    32'hFFFF_FFFF);
    run_phase(130);
    program_windows(32'h0000_0100, 32'h0000_00C0, 32'h0000_0080, 32'h0000_0200, 32'd4);
    run_phase(130);
    program_windows(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd0);
    run_phase(130);
    program_windows(32'h0000_0000, 32'h0000_0000, 32'h0000_8000, 32'hFFFF_0000,
                    32'h0100_0000);
    run_phase(130);
    repeat (2) begin
      program_windows($urandom_range(0, 32'h1FFFF), $urandom(), $urandom_range(0, 32'hFFFF),
                      $urandom(), $urandom_range(0, 256));
      run_phase(120);
    end

    repeat (20) @(posedge clk);
    if (results_due.size() != 0) note_mismatch("missing transactions", results_due.size(), 0);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
